### rtl/adl_pkg.sv
// Shared types and constants for the accumulation/distribution line.
// No dependencies; imported by the front, queue, back and top-level modules.
package adl_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [63:0] TOTAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TOTAL_MIN = 64'h8000_0000_0000_0000;

    // Per-bar classification produced by the front and consumed by the back.
    typedef struct packed {
        logic start;   // series start: clear the total
        logic flat;    // high equals low: total unchanged
        logic neg;     // ratio is negative
    } bar_flags_t;

    localparam int FLAGS_WIDTH = $bits(bar_flags_t);

endpackage

### rtl/accumulation_distribution_line.sv
// Accumulation/distribution line. Each bar passes the front register and the
// queue into the back part, which runs the iterative ratio divider unless the
// ratio saturates to +-1 or the bar is a series-start/flat bar. The back part
// takes a new bar only when idle, so it works on one bar at a time.
// Reset (rst_n, async): clears the running total to zero and empties the pipe.
module accumulation_distribution_line
    import adl_pkg::*;
#(
    parameter int PRICE_WIDTH  = 32,
    parameter int AMOUNT_WIDTH = 48,
    parameter int FRAC_BITS    = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [PRICE_WIDTH-1:0]  high_price,
    input  logic [PRICE_WIDTH-1:0]  low_price,
    input  logic [PRICE_WIDTH-1:0]  close_price,
    input  logic [AMOUNT_WIDTH-1:0] traded_amount,
    input  logic                    series_start,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [63:0]      ad_total
);

    localparam int EW = FLAGS_WIDTH + (PRICE_WIDTH + 1) + PRICE_WIDTH + AMOUNT_WIDTH;

    logic                    push_valid;
    logic                    push_ready;
    bar_flags_t              push_flags;
    logic [PRICE_WIDTH:0]    push_num_mag;
    logic [PRICE_WIDTH-1:0]  push_den_mag;
    logic [AMOUNT_WIDTH-1:0] push_amount;
    logic [EW-1:0]           push_data;

    logic                    pop_valid;
    logic                    pop_ready;
    logic [EW-1:0]           pop_data;
    bar_flags_t              pop_flags;

    adl_front #(
        .PRICE_WIDTH  (PRICE_WIDTH),
        .AMOUNT_WIDTH (AMOUNT_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .high_price    (high_price),
        .low_price     (low_price),
        .close_price   (close_price),
        .traded_amount (traded_amount),
        .series_start  (series_start),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_flags    (push_flags),
        .push_num_mag  (push_num_mag),
        .push_den_mag  (push_den_mag),
        .push_amount   (push_amount)
    );

    assign push_data = {push_flags, push_num_mag, push_den_mag, push_amount};

    adl_queue #(
        .WIDTH (EW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign pop_flags = pop_data[EW-1 -: FLAGS_WIDTH];

    adl_back #(
        .PRICE_WIDTH  (PRICE_WIDTH),
        .AMOUNT_WIDTH (AMOUNT_WIDTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_flags   (pop_flags),
        .pop_num_mag (pop_data[AMOUNT_WIDTH + PRICE_WIDTH +: PRICE_WIDTH + 1]),
        .pop_den_mag (pop_data[AMOUNT_WIDTH +: PRICE_WIDTH]),
        .pop_amount  (pop_data[AMOUNT_WIDTH-1:0]),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ad_total    (ad_total)
    );

endmodule

### rtl/adl_front.sv
// Input stage: registers one bar and classifies it (sign, magnitudes, flags).
// Depends on adl_pkg.
module adl_front
    import adl_pkg::*;
#(
    parameter int PRICE_WIDTH  = 32,
    parameter int AMOUNT_WIDTH = 48
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [PRICE_WIDTH-1:0]    high_price,
    input  logic [PRICE_WIDTH-1:0]    low_price,
    input  logic [PRICE_WIDTH-1:0]    close_price,
    input  logic [AMOUNT_WIDTH-1:0]   traded_amount,
    input  logic                      series_start,
    output logic                      push_valid,
    input  logic                      push_ready,
    output bar_flags_t                push_flags,
    output logic [PRICE_WIDTH:0]      push_num_mag,
    output logic [PRICE_WIDTH-1:0]    push_den_mag,
    output logic [AMOUNT_WIDTH-1:0]   push_amount
);

    localparam int NW = PRICE_WIDTH + 2;
    localparam int DW = PRICE_WIDTH + 1;

    logic                    valid_reg;
    logic [PRICE_WIDTH-1:0]  high_reg;
    logic [PRICE_WIDTH-1:0]  low_reg;
    logic [PRICE_WIDTH-1:0]  close_reg;
    logic [AMOUNT_WIDTH-1:0] amount_reg;
    logic                    start_reg;

    logic signed [NW-1:0]    num;
    logic signed [DW-1:0]    den;
    logic [NW-1:0]           num_abs;
    logic [DW-1:0]           den_abs;

    assign in_ready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            high_reg   <= high_price;
            low_reg    <= low_price;
            close_reg  <= close_price;
            amount_reg <= traded_amount;
            start_reg  <= series_start;
        end
    end

    // num = 2*close - high - low, den = high - low, both exact in signed form
    always_comb
    begin
        num = $signed({1'b0, close_reg, 1'b0})
            - $signed({2'b00, high_reg})
            - $signed({2'b00, low_reg});
        den = $signed({1'b0, high_reg}) - $signed({1'b0, low_reg});
        num_abs = num[NW-1] ? NW'(-num) : NW'(num);
        den_abs = den[DW-1] ? DW'(-den) : DW'(den);
    end

    assign push_flags.start = start_reg;
    assign push_flags.flat  = (high_reg == low_reg);
    assign push_flags.neg   = num[NW-1] ^ den[DW-1];
    assign push_num_mag     = num_abs[PRICE_WIDTH:0];
    assign push_den_mag     = den_abs[PRICE_WIDTH-1:0];
    assign push_amount      = amount_reg;

endmodule

### rtl/adl_queue.sv
// Short register FIFO between the front and back parts.
// Depends on adl_pkg for its depth.
module adl_queue
    import adl_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(p + 1'b1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= CW'(count_reg + 1'b1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= CW'(count_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/adl_back.sv
// Back part: restoring divider for the ratio, split multiply by the amount,
// saturating accumulate into the running total, and the output register.
// Depends on adl_pkg.
module adl_back
    import adl_pkg::*;
#(
    parameter int PRICE_WIDTH  = 32,
    parameter int AMOUNT_WIDTH = 48,
    parameter int FRAC_BITS    = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    pop_valid,
    output logic                    pop_ready,
    input  bar_flags_t              pop_flags,
    input  logic [PRICE_WIDTH:0]    pop_num_mag,
    input  logic [PRICE_WIDTH-1:0]  pop_den_mag,
    input  logic [AMOUNT_WIDTH-1:0] pop_amount,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [63:0]      ad_total
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CHK  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MLO  = 3'd3;
    localparam logic [2:0] ST_MHI  = 3'd4;
    localparam logic [2:0] ST_CMB  = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    localparam int RW   = FRAC_BITS + 1;
    localparam int LO_W = (AMOUNT_WIDTH + 1) / 2;
    localparam int HI_W = AMOUNT_WIDTH - LO_W;
    localparam int MW   = RW + LO_W;
    localparam int PW   = RW + AMOUNT_WIDTH;
    localparam int SW   = ((PW > 64) ? PW : 64) + 2;
    localparam int CW   = (FRAC_BITS > 1) ? $clog2(FRAC_BITS) : 1;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    bar_flags_t              flags_reg;
    logic [PRICE_WIDTH:0]    rem_reg;
    logic [PRICE_WIDTH-1:0]  den_reg;
    logic [AMOUNT_WIDTH-1:0] amt_reg;
    logic [RW-1:0]           quo_reg;
    logic [CW-1:0]           cnt_reg;
    logic [MW-1:0]           mult_reg;
    logic [PW-1:0]           prod_reg;
    logic [63:0]             total_reg;
    logic [63:0]             total_next;
    logic                    out_valid_reg;
    logic [63:0]             out_reg;

    logic                    out_free;
    logic [PRICE_WIDTH+1:0]  rem_sh;
    logic                    rem_ge;
    logic [PRICE_WIDTH:0]    rem_step;
    logic [MW-1:0]           mult_opa;
    logic [MW-1:0]           mult_opb;
    logic signed [SW-1:0]    sum;
    logic signed [SW-1:0]    delta;

    assign out_free  = !out_valid_reg || out_ready;
    assign pop_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign ad_total  = $signed(out_reg);

    // One quotient bit per cycle
    always_comb
    begin
        rem_sh   = {rem_reg, 1'b0};
        rem_ge   = (rem_sh >= {2'b00, den_reg});
        rem_step = rem_ge ? (PRICE_WIDTH+1)'(rem_sh - {2'b00, den_reg})
                          : rem_sh[PRICE_WIDTH:0];
    end

    // Shared multiplier: low half of the amount, then the high half
    always_comb
    begin
        mult_opa = MW'(quo_reg);
        if (state_reg == ST_MHI)
        begin
            mult_opb = MW'(amt_reg[AMOUNT_WIDTH-1:LO_W]);
        end
        else
        begin
            mult_opb = MW'(amt_reg[LO_W-1:0]);
        end
    end

    // Exact sum in a wider signed word, then clamp to 64 bits; start clears, flat holds
    always_comb
    begin
        delta = flags_reg.neg ? -$signed({{(SW-PW){1'b0}}, prod_reg})
                              :  $signed({{(SW-PW){1'b0}}, prod_reg});
        sum   = $signed({{(SW-64){total_reg[63]}}, total_reg}) + delta;
        if (flags_reg.start)
        begin
            total_next = '0;
        end
        else if (flags_reg.flat)
        begin
            total_next = total_reg;
        end
        else if (sum > $signed({{(SW-64){1'b0}}, TOTAL_MAX}))
        begin
            total_next = TOTAL_MAX;
        end
        else if (sum < $signed({{(SW-64){1'b1}}, TOTAL_MIN}))
        begin
            total_next = TOTAL_MIN;
        end
        else
        begin
            total_next = sum[63:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    if (pop_flags.start || pop_flags.flat)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_CHK;
                    end
                end
            end
            ST_CHK:
            begin
                state_next = ({1'b0, den_reg} <= rem_reg) ? ST_MLO : ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == CW'(FRAC_BITS - 1))
                begin
                    state_next = ST_MLO;
                end
            end
            ST_MLO: state_next = ST_MHI;
            ST_MHI: state_next = ST_CMB;
            ST_CMB: state_next = ST_FIN;
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FIN && out_free)
            begin
                total_reg     <= total_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    flags_reg <= pop_flags;
                    rem_reg   <= pop_num_mag;
                    den_reg   <= pop_den_mag;
                    amt_reg   <= pop_amount;
                end
            end
            ST_CHK:
            begin
                // Ratio at or beyond one saturates to one
                quo_reg <= ({1'b0, den_reg} <= rem_reg) ? RW'(1) << FRAC_BITS : '0;
                cnt_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= rem_step;
                quo_reg <= {quo_reg[RW-2:0], rem_ge};
                cnt_reg <= CW'(cnt_reg + 1'b1);
            end
            ST_MLO:
            begin
                mult_reg <= MW'(mult_opa * mult_opb);
            end
            ST_MHI:
            begin
                prod_reg <= PW'(mult_reg);
                mult_reg <= MW'(mult_opa * mult_opb);
            end
            ST_CMB:
            begin
                prod_reg <= PW'(prod_reg + (PW'(mult_reg) << LO_W));
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_reg <= total_next;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
